@@ sv/dcpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Command port package
// Shared types, command codes and sizes for the command port and its
// table loader.
// ----------------------------------------------------------------------------
`default_nettype none

package dcpt_pkg;

  // Default depth of the parameter FIFO, in 32-bit words.
  localparam int unsigned FIFO_DEPTH_DEF = 32;

  // Entries in each of the light, color and scale tables.
  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  // The light and color tables are stored four bytes to a row, the scale
  // table two halfwords to a row.
  localparam int unsigned BYTE_ROWS     = TABLE_ENTRIES / 4;
  localparam int unsigned HALF_ROWS     = TABLE_ENTRIES / 2;
  localparam int unsigned BYTE_ROW_W    = $clog2(BYTE_ROWS);
  localparam int unsigned HALF_ROW_W    = $clog2(HALF_ROWS);

  // Command codes carried in bits 31..29 of a command word.
  localparam logic [2:0] CMD_DECODE = 3'd1;
  localparam logic [2:0] CMD_LIGHT  = 3'd2;
  localparam logic [2:0] CMD_SCALE  = 3'd3;

  // Table selects for a readback.
  localparam logic [1:0] SEL_LIGHT = 2'd0;
  localparam logic [1:0] SEL_COLOR = 2'd1;
  localparam logic [1:0] SEL_SCALE = 2'd2;

  // Port operations.
  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_DATA   = 2'd1,
    OP_CTRL   = 2'd2,
    OP_TREAD  = 2'd3
  } op_kind_e;

  // One classified port operation, as it travels from front to back.
  typedef struct packed {
    op_kind_e               kind;
    logic [31:0]            data;
    logic [1:0]             sel;
    logic [IDX_W-1:0]       idx;
    logic [2:0]             code;     // command code of a command word
    logic [3:0]             fmt;      // output format bits of a command word
    logic [15:0]            wr_init;  // words remaining once the word is taken
    logic                   starts;   // the command word starts a run
  } op_t;

endpackage

`default_nettype wire

@@ sv/dcpt_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = dcpt_pkg::FIFO_DEPTH_DEF,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ sv/dcpt_front.sv @@
// ----------------------------------------------------------------------------
// Command port front end
// Takes port transfers, decodes command word fields and queues the
// classified operation for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpt_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [31:0]                 wdata_i,
  input  wire logic [1:0]                  table_sel_i,
  input  wire logic [dcpt_pkg::IDX_W-1:0]  table_index_i,
  output logic                             head_valid_o,
  output dcpt_pkg::op_t                    head_o,
  input  wire logic                        pop_i
);

  dcpt_pkg::op_t op;
  dcpt_pkg::op_t q_mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          push;

  // Decode the command word fields up front; they do not depend on state.
  always_comb begin
    op.kind = dcpt_pkg::op_kind_e'(cmd_i);
    op.data = wdata_i;
    op.sel  = table_sel_i;
    op.idx  = table_index_i;
    op.code = wdata_i[31:29];
    op.fmt  = wdata_i[28:25];
    case (wdata_i[31:29])
      dcpt_pkg::CMD_LIGHT:  op.wr_init = wdata_i[0] ? 16'd31 : 16'd15;
      dcpt_pkg::CMD_SCALE:  op.wr_init = 16'd31;
      dcpt_pkg::CMD_DECODE: op.wr_init = wdata_i[15:0] - 16'd1;
      default:              op.wr_init = wdata_i[15:0];
    endcase
    op.starts = wdata_i[31:29] inside {dcpt_pkg::CMD_DECODE, dcpt_pkg::CMD_LIGHT,
                                       dcpt_pkg::CMD_SCALE};
  end

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = q_mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= op;
    end
  end

endmodule

`default_nettype wire

@@ sv/dcpt_back.sv @@
// ----------------------------------------------------------------------------
// Command port back end
// Holds the command state, the parameter FIFO and the three tables, carries
// out queued operations and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcpt_back #(
  parameter int unsigned FIFO_DEPTH = dcpt_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          head_valid_i,
  input  wire dcpt_pkg::op_t head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [31:0]        rdata_o,
  output logic               error_o
);

  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned BRW = dcpt_pkg::BYTE_ROW_W;
  localparam int unsigned HRW = dcpt_pkg::HALF_ROW_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_PUSH  = 2'd2;
  localparam logic [1:0] ST_RESP  = 2'd3;

  typedef enum logic [1:0] {
    DK_NONE        = 2'd0,
    DK_LIGHT       = 2'd1,
    DK_LIGHT_COLOR = 2'd2,
    DK_SCALE       = 2'd3
  } drain_e;

  typedef struct packed {
    logic   err;
    drain_e dk;
  } exec_plan_t;

  // Decides what running the pending command on n FIFO words does.
  function automatic exec_plan_t plan_exec(logic [2:0] code, logic n16, logic n32);
    exec_plan_t p;
    p.err = 1'b0;
    p.dk  = DK_NONE;
    case (code)
      dcpt_pkg::CMD_DECODE: p.err = !n32;
      dcpt_pkg::CMD_LIGHT: begin
        if (n16) begin
          p.dk = DK_LIGHT;
        end else if (n32) begin
          p.dk = DK_LIGHT_COLOR;
        end else begin
          p.err = 1'b1;
        end
      end
      dcpt_pkg::CMD_SCALE: begin
        if (n32) begin
          p.dk = DK_SCALE;
        end else begin
          p.err = 1'b1;
        end
      end
      default: p = p;
    endcase
    return p;
  endfunction

  // Control and command state.
  logic [1:0]    state_q, state_d;
  logic [2:0]    code_q, code_d;
  logic [3:0]    fmt_q, fmt_d;
  logic [15:0]   wr_q, wr_d;
  logic          running_q, running_d;
  logic          ien_q, ien_d;
  logic          b18_q, b18_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [4:0]    k_q, k_d;
  drain_e        dk_q, dk_d;
  logic          ret_push_q, ret_push_d;
  logic          out_valid_q, out_valid_d;
  logic          tw_v_q;

  // Payload registers.
  dcpt_pkg::op_t op_q, op_d;
  logic [31:0]   res_rdata_q, res_rdata_d;
  logic          res_err_q, res_err_d;
  logic          tvld_q, tvld_d;
  logic [4:0]    tw_k_q;
  logic [31:0]   rdata_q, rdata_d;
  logic          error_q, error_d;

  logic [dcpt_pkg::BYTE_ROWS-1:0] light_vld_q, color_vld_q;
  logic [dcpt_pkg::HALF_ROWS-1:0] scale_vld_q;

  exec_plan_t  plan_pre, plan_post;
  logic        full, out_free, tread_re, last_k;
  logic [31:0] status, tread_data, fifo_rd, light_rd, color_rd, scale_rd;
  logic        light_we, color_we, scale_we;

  assign full     = (cnt_q == CW'(FIFO_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;
  assign last_k   = (dk_q == DK_LIGHT) ? (k_q == 5'd15) : (k_q == 5'd31);
  assign tread_re = (state_q == ST_IDLE) && head_valid_i && (head_i.kind == dcpt_pkg::OP_TREAD);

  // A full FIFO runs the command on all its words; the last parameter runs
  // it on the count plus the word being pushed.
  assign plan_pre  = plan_exec(code_q, cnt_q == CW'(16), cnt_q == CW'(32));
  assign plan_post = plan_exec(code_q, cnt_q == CW'(15), cnt_q == CW'(31));

  always_comb begin
    status        = '0;
    status[31]    = 1'b1;
    status[30]    = full;
    status[29]    = running_q;
    status[28]    = ien_q && running_q && !full;
    status[26:23] = fmt_q;
    status[18]    = b18_q;
    status[15:0]  = wr_q;
  end

  // Table writes come in the cycle after the FIFO read of the drain.
  assign light_we = tw_v_q && ((dk_q == DK_LIGHT) || ((dk_q == DK_LIGHT_COLOR) && !tw_k_q[4]));
  assign color_we = tw_v_q && (dk_q == DK_LIGHT_COLOR) && tw_k_q[4];
  assign scale_we = tw_v_q && (dk_q == DK_SCALE);

  dcpt_ram #(.WIDTH(32), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_PUSH),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (op_q.data),
    .re_i    (state_q == ST_DRAIN),
    .raddr_i (AW'(k_q)),
    .rdata_o (fifo_rd)
  );

  dcpt_ram #(.WIDTH(32), .DEPTH(dcpt_pkg::BYTE_ROWS)) u_light_ram (
    .clk_i   (clk_i),
    .we_i    (light_we),
    .waddr_i (tw_k_q[BRW-1:0]),
    .wdata_i (fifo_rd),
    .re_i    (tread_re),
    .raddr_i (head_i.idx[dcpt_pkg::IDX_W-1:2]),
    .rdata_o (light_rd)
  );

  dcpt_ram #(.WIDTH(32), .DEPTH(dcpt_pkg::BYTE_ROWS)) u_color_ram (
    .clk_i   (clk_i),
    .we_i    (color_we),
    .waddr_i (tw_k_q[BRW-1:0]),
    .wdata_i (fifo_rd),
    .re_i    (tread_re),
    .raddr_i (head_i.idx[dcpt_pkg::IDX_W-1:2]),
    .rdata_o (color_rd)
  );

  dcpt_ram #(.WIDTH(32), .DEPTH(dcpt_pkg::HALF_ROWS)) u_scale_ram (
    .clk_i   (clk_i),
    .we_i    (scale_we),
    .waddr_i (tw_k_q[HRW-1:0]),
    .wdata_i (fifo_rd),
    .re_i    (tread_re),
    .raddr_i (head_i.idx[dcpt_pkg::IDX_W-1:1]),
    .rdata_o (scale_rd)
  );

  // Readback value; a row never written reads as zero.
  always_comb begin
    tread_data = '0;
    if (tvld_q) begin
      case (op_q.sel)
        dcpt_pkg::SEL_LIGHT: tread_data = 32'(light_rd[{op_q.idx[1:0], 3'b000} +: 8]);
        dcpt_pkg::SEL_COLOR: tread_data = 32'(color_rd[{op_q.idx[1:0], 3'b000} +: 8]);
        dcpt_pkg::SEL_SCALE: tread_data = 32'(scale_rd[{op_q.idx[0], 4'b0000} +: 16]);
        default:             tread_data = '0;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    fmt_d       = fmt_q;
    wr_d        = wr_q;
    running_d   = running_q;
    ien_d       = ien_q;
    b18_d       = b18_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    dk_d        = dk_q;
    ret_push_d  = ret_push_q;
    op_d        = op_q;
    res_rdata_d = res_rdata_q;
    res_err_d   = res_err_q;
    tvld_d      = tvld_q;
    out_valid_d = out_valid_q && out_stall_i;
    rdata_d     = rdata_q;
    error_d     = error_q;
    pop_o       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (head_valid_i) begin
          pop_o       = 1'b1;
          op_d        = head_i;
          res_rdata_d = '0;
          res_err_d   = 1'b0;
          state_d     = ST_RESP;
          case (head_i.kind)
            dcpt_pkg::OP_STATUS: res_rdata_d = status;
            dcpt_pkg::OP_DATA: begin
              if (running_q) begin
                state_d = ST_PUSH;
                if (full) begin
                  res_err_d = plan_pre.err;
                  cnt_d     = '0;
                  if (plan_pre.dk != DK_NONE) begin
                    dk_d       = plan_pre.dk;
                    k_d        = '0;
                    ret_push_d = 1'b1;
                    state_d    = ST_DRAIN;
                  end
                end
              end else begin
                code_d    = head_i.code;
                fmt_d     = head_i.fmt;
                wr_d      = head_i.wr_init;
                running_d = head_i.starts;
              end
            end
            dcpt_pkg::OP_CTRL: begin
              ien_d = head_i.data[30];
              if (head_i.data[31]) begin
                b18_d     = 1'b1;
                cnt_d     = '0;
                code_d    = '0;
                fmt_d     = '0;
                wr_d      = '0;
                running_d = 1'b0;
                ien_d     = 1'b0;
              end
            end
            dcpt_pkg::OP_TREAD: begin
              case (head_i.sel)
                dcpt_pkg::SEL_LIGHT: tvld_d = light_vld_q[head_i.idx[dcpt_pkg::IDX_W-1:2]];
                dcpt_pkg::SEL_COLOR: tvld_d = color_vld_q[head_i.idx[dcpt_pkg::IDX_W-1:2]];
                dcpt_pkg::SEL_SCALE: tvld_d = scale_vld_q[head_i.idx[dcpt_pkg::IDX_W-1:1]];
                default:             tvld_d = 1'b0;
              endcase
            end
            default: state_d = ST_RESP;
          endcase
        end
      end
      ST_DRAIN: begin
        k_d = k_q + 5'd1;
        if (last_k) begin
          state_d = ret_push_q ? ST_PUSH : ST_RESP;
        end
      end
      ST_PUSH: begin
        wr_d    = wr_q - 16'd1;
        state_d = ST_RESP;
        if (wr_q == 16'd0) begin
          running_d = 1'b0;
          cnt_d     = '0;
          res_err_d = res_err_q || plan_post.err;
          if (plan_post.dk != DK_NONE) begin
            dk_d       = plan_post.dk;
            k_d        = '0;
            ret_push_d = 1'b0;
            state_d    = ST_DRAIN;
          end
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rdata_d     = (op_q.kind == dcpt_pkg::OP_TREAD) ? tread_data : res_rdata_q;
          error_d     = res_err_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      code_q      <= '0;
      fmt_q       <= '0;
      wr_q        <= '0;
      running_q   <= 1'b0;
      ien_q       <= 1'b0;
      b18_q       <= 1'b0;
      cnt_q       <= '0;
      k_q         <= '0;
      dk_q        <= DK_NONE;
      ret_push_q  <= 1'b0;
      out_valid_q <= 1'b0;
      tw_v_q      <= 1'b0;
      light_vld_q <= '0;
      color_vld_q <= '0;
      scale_vld_q <= '0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      fmt_q       <= fmt_d;
      wr_q        <= wr_d;
      running_q   <= running_d;
      ien_q       <= ien_d;
      b18_q       <= b18_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      dk_q        <= dk_d;
      ret_push_q  <= ret_push_d;
      out_valid_q <= out_valid_d;
      tw_v_q      <= (state_q == ST_DRAIN);
      if (light_we) begin
        light_vld_q[tw_k_q[BRW-1:0]] <= 1'b1;
      end
      if (color_we) begin
        color_vld_q[tw_k_q[BRW-1:0]] <= 1'b1;
      end
      if (scale_we) begin
        scale_vld_q[tw_k_q[HRW-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    res_rdata_q <= res_rdata_d;
    res_err_q   <= res_err_d;
    tvld_q      <= tvld_d;
    tw_k_q      <= k_q;
    rdata_q     <= rdata_d;
    error_q     <= error_d;
  end

  assign out_valid_o = out_valid_q;
  assign rdata_o     = rdata_q;
  assign error_o     = error_q;

`ifndef SYNTHESIS
  a_tw_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tw_v_q |-> $past(state_q == ST_DRAIN))
    else $error("table write without a preceding drain read");

  a_idle_fifo_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (cnt_q == '0))
    else $error("parameter FIFO holds words while no command runs");

  a_finish_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && wr_q == 16'd0) |=> (cnt_q == '0 && !running_q))
    else $error("last parameter did not end the command");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside the response step");
`endif

endmodule

`default_nettype wire

@@ sv/decoder_command_port_table_loader_top.sv @@
// ----------------------------------------------------------------------------
// Decoder command port and table loader
// Command/parameter port of a macroblock decoder with its light, color and
// scale table loader, status packing and table readback.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  ---------------------------
//   in        slave      in_valid_i / in_stall_o   cmd_i, wdata_i, table_sel_i,
//                                                  table_index_i
//   out       master     out_valid_o / out_stall_i rdata_o, error_o
//
// A status read, control write, command word or table readback passes the back
// end's idle and response states; a parameter also passes the push state, which
// writes the parameter FIFO. A transfer is accepted into the front queue while
// earlier ones are carried out. A parameter that runs a table command, as the
// last one or because it finds the FIFO full, adds a drain of 16 or 32 FIFO
// words, one word per cycle through the FIFO memory's single read port. A
// parameter drains at most once, since after a full FIFO runs it holds a
// single word. Reset is asynchronous and active low; the tables read as zero
// until first loaded. A stalled result waits in the output register, and the
// two-entry queue stalls the input only when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module decoder_command_port_table_loader_top #(
  parameter int unsigned FIFO_DEPTH = dcpt_pkg::FIFO_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [1:0]                  cmd_i,
  input  wire logic [31:0]                 wdata_i,
  input  wire logic [1:0]                  table_sel_i,
  input  wire logic [dcpt_pkg::IDX_W-1:0]  table_index_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [31:0]                      rdata_o,
  output logic                             error_o
);

  // Classified operations waiting for the back end.
  logic          head_valid;
  dcpt_pkg::op_t head;
  logic          pop;

  // The front end decodes and queues each transfer, so it takes transfers until
  // its queue is full while the back end drains the parameter FIFO into a table.
  dcpt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .wdata_i       (wdata_i),
    .table_sel_i   (table_sel_i),
    .table_index_i (table_index_i),
    .head_valid_o  (head_valid),
    .head_o        (head),
    .pop_i         (pop)
  );

  // The back end owns all command state, the parameter FIFO and the tables,
  // and returns exactly one result per operation through its output register.
  dcpt_back #(.FIFO_DEPTH(FIFO_DEPTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .rdata_o      (rdata_o),
    .error_o      (error_o)
  );

endmodule

`default_nettype wire

@@ tb/tb_decoder_command_port_table_loader_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Command port and table loader testbench
// Drives status reads, data port writes, control writes and table readbacks
// through the input channel and checks every reply against an in-order
// prediction of the port state, the parameter FIFO and the three tables.
// ----------------------------------------------------------------------------

module tb_decoder_command_port_table_loader_top;

  localparam int unsigned PDEPTH      = dcpt_pkg::FIFO_DEPTH_DEF;
  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned RESET_CYCLES = 7;
  // Idle percentage for both the sender and the receiver.
  localparam int unsigned IDLE_PCT    = 28;
  // Cycles to watch for stray replies once every reply has come. This covers
  // a full-FIFO drain followed by a table drain, with plenty of margin.
  localparam int unsigned TAIL_CYCLES = 200;
  // Hard stop for the run, in nanoseconds, several times the slowest legal run.
  localparam int unsigned RUN_LIMIT_NS = 6_000_000;

  // Command codes that never start a run.
  localparam logic [2:0] CMD_NONE        = 3'd0;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd4;
  // Table select that reads back as zero.
  localparam logic [1:0] SEL_NONE        = 2'd3;

  // Control word bits.
  localparam int unsigned CTRL_RESET   = 31;
  localparam int unsigned CTRL_IN_DMA  = 30;
  localparam int unsigned CTRL_OUT_DMA = 29;

  typedef struct packed {
    logic [31:0] rdata;
    logic        err;
  } port_reply_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block under test. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic [1:0]  cmd_i         = '0;
  logic [31:0] wdata_i       = '0;
  logic [1:0]  table_sel_i   = '0;
  logic [dcpt_pkg::IDX_W-1:0] table_index_i = '0;
  logic        out_stall_i   = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [31:0] rdata_o;
  logic        error_o;

  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  decoder_command_port_table_loader_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .wdata_i       (wdata_i),
    .table_sel_i   (table_sel_i),
    .table_index_i (table_index_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rdata_o       (rdata_o),
    .error_o       (error_o)
  );

  // --------------------------------------------------------------------------
  // Predicted state of the port. It is advanced once per accepted transfer,
  // in the order the transfers were accepted, so it always matches the state
  // the block will be in when it answers that transfer.
  // --------------------------------------------------------------------------
  logic [2:0]  cur_code   = '0;
  logic [3:0]  cur_fmt    = '0;
  logic [15:0] words_left = '0;
  logic        busy       = 1'b0;
  logic        in_dma     = 1'b0;
  logic        out_dma    = 1'b0;
  logic        base18     = 1'b0;
  logic [5:0]  pcount     = '0;
  logic [31:0] pfifo     [PDEPTH]                  = '{default: '0};
  logic [7:0]  light_tbl [dcpt_pkg::TABLE_ENTRIES] = '{default: '0};
  logic [7:0]  color_tbl [dcpt_pkg::TABLE_ENTRIES] = '{default: '0};
  logic [15:0] scale_tbl [dcpt_pkg::TABLE_ENTRIES] = '{default: '0};

  // Replies still owed by the block, oldest first.
  port_reply_t replies_due[$];
  port_reply_t head_reply;
  int unsigned mismatches = 0;

  // Both sides drop their random idling while this is set.
  logic        steady = 1'b0;
  // Cycles for which the receiver still holds off unconditionally.
  int unsigned hold_left = 0;

  // Random table select and entry index, at the widths of their ports.
  function automatic logic [1:0] rand_sel();
    logic [31:0] r;
    r = $urandom();
    return r[1:0];
  endfunction

  function automatic logic [dcpt_pkg::IDX_W-1:0] rand_idx();
    logic [31:0] r;
    r = $urandom();
    return r[dcpt_pkg::IDX_W-1:0];
  endfunction

  // Runs the pending command on the parameters collected so far and empties
  // the FIFO. Returns the error flag for a wrong parameter count.
  function automatic logic apply_pending_command();
    logic bad;
    int   w;
    int   b;
    bad = 1'b0;
    case (cur_code)
      dcpt_pkg::CMD_DECODE: begin
        // The block payload is only counted, never kept.
        bad = (pcount != 6'd32);
      end
      dcpt_pkg::CMD_LIGHT: begin
        if (pcount == 6'd16 || pcount == 6'd32) begin
          for (w = 0; w < 16; w++)
            for (b = 0; b < 4; b++)
              light_tbl[w * 4 + b] = pfifo[w][b * 8 +: 8];
          // With a full 32-word payload the second half fills the color table.
          if (pcount == 6'd32)
            for (w = 0; w < 16; w++)
              for (b = 0; b < 4; b++)
                color_tbl[w * 4 + b] = pfifo[16 + w][b * 8 +: 8];
        end else begin
          bad = 1'b1;
        end
      end
      dcpt_pkg::CMD_SCALE: begin
        if (pcount == 6'd32) begin
          for (w = 0; w < 32; w++) begin
            scale_tbl[w * 2]     = pfifo[w][15:0];
            scale_tbl[w * 2 + 1] = pfifo[w][31:16];
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: ;
    endcase
    pcount = '0;
    return bad;
  endfunction

  // Works out the reply to one accepted transfer and queues it.
  task automatic predict_reply(input dcpt_pkg::op_kind_e op, input logic [31:0] data,
                               input logic [1:0] sel,
                               input logic [dcpt_pkg::IDX_W-1:0] idx);
    port_reply_t r;
    logic        full;
    r.rdata = '0;
    r.err   = 1'b0;
    case (op)
      dcpt_pkg::OP_STATUS: begin
        full        = (pcount >= PDEPTH);
        r.rdata[31] = 1'b1;  // output FIFO is always empty
        r.rdata[30] = full;
        r.rdata[29] = busy;
        r.rdata[28] = in_dma && busy && !full;
        r.rdata[26:23] = cur_fmt;
        r.rdata[18] = base18;
        r.rdata[15:0] = words_left;
      end
      dcpt_pkg::OP_DATA: begin
        if (busy) begin
          // A parameter that finds the FIFO full first runs what is there.
          if (pcount >= PDEPTH)
            r.err |= apply_pending_command();
          pfifo[pcount % PDEPTH] = data;
          pcount = pcount + 6'd1;
          if (words_left == 16'd0) begin
            r.err |= apply_pending_command();
            busy = 1'b0;
          end
          words_left = words_left - 16'd1;
        end else begin
          cur_code   = data[31:29];
          cur_fmt    = data[28:25];
          words_left = data[15:0];
          if (cur_code == dcpt_pkg::CMD_LIGHT)
            words_left = data[0] ? 16'd32 : 16'd16;
          if (cur_code == dcpt_pkg::CMD_SCALE)
            words_left = 16'd32;
          if (cur_code == dcpt_pkg::CMD_DECODE || cur_code == dcpt_pkg::CMD_LIGHT ||
              cur_code == dcpt_pkg::CMD_SCALE) begin
            busy       = 1'b1;
            words_left = words_left - 16'd1;
          end
        end
      end
      dcpt_pkg::OP_CTRL: begin
        in_dma  = data[CTRL_IN_DMA];
        out_dma = data[CTRL_OUT_DMA];
        if (data[CTRL_RESET]) begin
          base18     = 1'b1;
          pcount     = '0;
          cur_code   = CMD_NONE;
          cur_fmt    = '0;
          words_left = '0;
          busy       = 1'b0;
          in_dma     = 1'b0;
          out_dma    = 1'b0;
        end
      end
      default: begin
        case (sel)
          dcpt_pkg::SEL_LIGHT: r.rdata = {24'd0, light_tbl[idx]};
          dcpt_pkg::SEL_COLOR: r.rdata = {24'd0, color_tbl[idx]};
          dcpt_pkg::SEL_SCALE: r.rdata = {16'd0, scale_tbl[idx]};
          default:             r.rdata = '0;
        endcase
      end
    endcase
    replies_due.push_back(r);
  endtask

  // --------------------------------------------------------------------------
  // Sender. Inputs change only at the falling edge; a transfer is taken at
  // the first rising edge where the block does not stall it. Valid stays high
  // with a steady payload until then, whatever the stall does.
  // --------------------------------------------------------------------------
  task automatic send_xfer(input dcpt_pkg::op_kind_e op, input logic [31:0] data,
                           input logic [1:0] sel,
                           input logic [dcpt_pkg::IDX_W-1:0] idx);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    cmd_i         = op;
    wdata_i       = data;
    table_sel_i   = sel;
    table_index_i = idx;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_reply(op, data, sel, idx);
  endtask

  // Fields that an operation ignores are filled with noise.
  task automatic status_read();
    send_xfer(dcpt_pkg::OP_STATUS, $urandom(), rand_sel(), rand_idx());
  endtask

  task automatic data_write(input logic [31:0] word);
    send_xfer(dcpt_pkg::OP_DATA, word, rand_sel(), rand_idx());
  endtask

  task automatic ctrl_write(input logic [31:0] word);
    send_xfer(dcpt_pkg::OP_CTRL, word, rand_sel(), rand_idx());
  endtask

  task automatic table_read(input logic [1:0] sel, input logic [dcpt_pkg::IDX_W-1:0] idx);
    send_xfer(dcpt_pkg::OP_TREAD, $urandom(), sel, idx);
  endtask

  // Builds a command word; the bits between the format and the count are
  // don't-care and get noise.
  function automatic logic [31:0] cmd_word(input logic [2:0] code, input logic [3:0] fmt,
                                           input logic [15:0] count);
    logic [8:0] pad;
    pad = 9'($urandom());
    return {code, fmt, pad, count};
  endfunction

  // Parameter payload, leaning on the all-zero and all-one words now and then.
  function automatic logic [31:0] param_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Drops valid and waits until every owed reply has been checked.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Receiver. It stalls at random, except during a steady stretch, and holds
  // off completely while a hold-off count is running down.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !steady && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Reply checking: every reply transfer is compared with the oldest owed one.
  // --------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t ns: %s is %h, expected %h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (replies_due.size() == 0) begin
        note_mismatch("reply with nothing owed, rdata", rdata_o, 32'h0);
      end else begin
        head_reply = replies_due.pop_front();
        if (rdata_o !== head_reply.rdata)
          note_mismatch("rdata", rdata_o, head_reply.rdata);
        if (error_o !== head_reply.err)
          note_mismatch("error", {31'd0, error_o}, {31'd0, head_reply.err});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Short directed pass over every operation while the port is idle: reset
  // values, readback extremes and the unused select, DMA enables, command
  // words that start nothing, a decode run with the wrong count, a zero count
  // that wraps to 65535, and a control reset that aborts that run.
  task automatic test_idle_port();
    status_read();
    table_read(dcpt_pkg::SEL_LIGHT, 6'd0);
    table_read(dcpt_pkg::SEL_COLOR, 6'd63);
    table_read(dcpt_pkg::SEL_SCALE, 6'd63);
    table_read(SEL_NONE, 6'd21);
    ctrl_write((32'd1 << CTRL_IN_DMA) | (32'd1 << CTRL_OUT_DMA));
    status_read();
    data_write(cmd_word(CMD_NONE, 4'hf, 16'hffff));
    status_read();
    // All ones carries one of the spare codes, so it only latches fields.
    data_write(32'hffff_ffff);
    status_read();
    data_write(cmd_word(CMD_SPARE_FIRST, 4'h0, 16'h0000));
    data_write(32'h0000_0000);
    // A decode run of a single parameter ends with a wrong count.
    data_write(cmd_word(dcpt_pkg::CMD_DECODE, 4'h5, 16'h0001));
    status_read();
    data_write(32'h0000_0000);
    status_read();
    // A zero count wraps, so this run would take 65536 parameters.
    data_write(cmd_word(dcpt_pkg::CMD_DECODE, 4'hf, 16'h0000));
    status_read();
    data_write(32'hffff_ffff);
    status_read();
    ctrl_write(32'hffff_ffff);
    status_read();
    ctrl_write(32'h0000_0000);
  endtask

  // Well-formed light/color and scale table loads with random content, with
  // status reads slipped in mid-run and random readbacks after each load.
  // Every fourth load the sender waits until every reply is back.
  task automatic test_table_loads(input int unsigned loads);
    int unsigned k;
    int unsigned p;
    int unsigned n;
    logic [31:0] word;
    logic [2:0]  code;
    for (k = 0; k < loads; k++) begin
      code = ($urandom_range(2) == 0) ? dcpt_pkg::CMD_SCALE : dcpt_pkg::CMD_LIGHT;
      word = cmd_word(code, 4'($urandom_range(15)), 16'($urandom()));
      n    = (code == dcpt_pkg::CMD_SCALE || word[0]) ? 32 : 16;
      data_write(word);
      for (p = 0; p < n; p++) begin
        if ($urandom_range(9) == 0)
          status_read();
        data_write(param_word());
      end
      repeat ($urandom_range(4, 8))
        table_read(rand_sel(), rand_idx());
      if (k % 4 == 3)
        wait_drained();
    end
  endtask

  // Decode runs of exactly one FIFO, more than one FIFO (so the full FIFO
  // runs first), short counts and random counts. DMA enables change now and
  // then during a run. The first runs go without any idling on either side.
  task automatic test_decode_runs();
    int unsigned r;
    int unsigned p;
    int unsigned n;
    for (r = 0; r < 10; r++) begin
      steady = (r < 3);
      case (r)
        0:       n = 32;
        1:       n = 33;
        2:       n = 65;
        3:       n = 1;
        4:       n = 31;
        5:       n = 64;
        default: n = $urandom_range(2, 70);
      endcase
      data_write(cmd_word(dcpt_pkg::CMD_DECODE, 4'($urandom_range(15)), 16'(n)));
      for (p = 0; p < n; p++) begin
        if ($urandom_range(15) == 0)
          ctrl_write($urandom() & ~(32'd1 << CTRL_RESET));
        if ($urandom_range(11) == 0)
          status_read();
        data_write(param_word());
      end
      status_read();
    end
    steady = 1'b0;
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering reads and control writes, so the block fills and stalls its
  // input. Afterwards the sender pauses until every reply has arrived.
  task automatic test_backpressure();
    int unsigned k;
    hold_left = 64;
    for (k = 0; k < 40; k++) begin
      case ($urandom_range(2))
        0:       status_read();
        1:       table_read(rand_sel(), rand_idx());
        default: ctrl_write($urandom() & ~(32'd1 << CTRL_RESET));
      endcase
    end
    wait_drained();
  endtask

  // Unshaped traffic: any operation with any field values. Random command
  // words start runs of any length, and random control resets cut them off.
  task automatic test_random_mix(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      steady = (k >= count / 3) && (k < 2 * count / 3);
      send_xfer(dcpt_pkg::op_kind_e'(rand_sel()), $urandom(), rand_sel(), rand_idx());
    end
    steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence of the run.
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_port();
    test_table_loads(12);
    test_decode_runs();
    test_backpressure();
    test_random_mix(150);

    // Every reply must arrive, and nothing more may follow.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // A hung handshake ends the run here.
  initial begin
    #(RUN_LIMIT_NS);
    $display("run limit reached with %0d replies still owed", replies_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
